// ===== hdl/gwm_pkg.sv =====
// Package for the grid word match block: field widths, codes, state and
// register types, and helpers that size the grid and word memories.
// No dependencies; every other file but gwm_ram imports it.
`default_nettype none

package gwm_pkg;

  // Defaults for the top-level parameters.
  localparam int GRID_DIM_DEF  = 32;
  localparam int MAX_WORDS_DEF = 1024;
  localparam int WORD_LEN_DEF  = 10;

  // Fixed field widths of the word channels and the configuration port.
  localparam int CMD_W     = 2;
  localparam int ROW_W     = 5;
  localparam int COL_W     = 5;
  localparam int WIDX_W    = 10;
  localparam int POS_W     = 4;
  localparam int CHAR_W    = 8;
  localparam int DIM_W     = 6;
  localparam int CFG_IDX_W = 1;

  // A stored word ends at its first newline byte.
  localparam logic [CHAR_W-1:0] END_MARK = 8'd10;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_CELL = 2'd0,
    CMD_WRITE_CHAR = 2'd1,
    CMD_SEARCH     = 2'd2,
    CMD_NOP        = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_COLS = 1'b0,
    REG_NUM_ROWS = 1'b1
  } reg_idx_t;

  // Search sequencer: one pass of H, V, D per word character.
  typedef enum logic [2:0] {
    S_IDLE,
    S_H,
    S_V,
    S_D,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [DIM_W-1:0] num_cols;
    logic [DIM_W-1:0] num_rows;
  } dims_t;

  // Address width of the grid memory, at least one bit.
  function automatic int grid_aw(input int dim);
    return (dim > 1) ? $clog2(dim * dim) : 1;
  endfunction

  // Address width of the word memory (each word has WORD_LEN+1 slots).
  function automatic int word_aw(input int max_words, input int word_len);
    return $clog2(max_words * (word_len + 1));
  endfunction

endpackage

`default_nettype wire

// ===== hdl/gwm_if.sv =====
// Word channel interfaces of the grid word match block: the command
// channel and the result channel, each with valid/ready handshake.
// Depends on gwm_pkg.
`default_nettype none

interface gwm_in_if import gwm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ROW_W-1:0]  cell_row;
  logic [COL_W-1:0]  cell_col;
  logic [WIDX_W-1:0] word_index;
  logic [POS_W-1:0]  char_pos;
  logic [CHAR_W-1:0] char_value;

  modport source (
    output valid, command, cell_row, cell_col, word_index, char_pos, char_value,
    input  ready
  );
  modport sink (
    input  valid, command, cell_row, cell_col, word_index, char_pos, char_value,
    output ready
  );
endinterface

interface gwm_out_if import gwm_pkg::*; ();
  logic valid;
  logic ready;
  logic match_horizontal;
  logic match_vertical;
  logic match_diagonal;

  modport source (
    output valid, match_horizontal, match_vertical, match_diagonal,
    input  ready
  );
  modport sink (
    input  valid, match_horizontal, match_vertical, match_diagonal,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/gwm_ram.sv =====
// Single-port-write, single-port-read memory with registered read data.
// Used for the grid store and the word store. Depends on nothing.
`default_nettype none

module gwm_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gwm_cfg.sv =====
// Configuration registers of the grid word match block: columns and rows
// in use, clamped to the legal range on write. Depends on gwm_pkg.
`default_nettype none

module gwm_cfg import gwm_pkg::*; #(
  parameter int GRID_DIM = GRID_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  output dims_t                dims
);

  // Largest storable value: the grid size, or what the field can hold.
  localparam int DimCap = (GRID_DIM < 63) ? GRID_DIM : 63;
  localparam int DimRst = (GRID_DIM < 32) ? GRID_DIM : 32;

  logic [DIM_W-1:0] clamped;

  // Zero counts as one; anything past the grid counts as the grid size.
  always_comb begin
    priority if (cfg_data == '0) begin
      clamped = DIM_W'(1);
    end else if (cfg_data > DIM_W'(DimCap)) begin
      clamped = DIM_W'(DimCap);
    end else begin
      clamped = cfg_data;
    end
  end

  // Register write.
  always_ff @(posedge clk) begin
    if (rst) begin
      dims.num_cols <= DIM_W'(DimRst);
      dims.num_rows <= DIM_W'(DimRst);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_NUM_COLS: dims.num_cols <= clamped;
        REG_NUM_ROWS: dims.num_rows <= clamped;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gwm_seq.sv =====
// Command decode and search sequencer of the grid word match block. One
// byte comparator is shared by the three directions, character by
// character. Depends on gwm_pkg and gwm_if; drives the two memories.
`default_nettype none

module gwm_seq import gwm_pkg::*; #(
  parameter int GRID_DIM  = GRID_DIM_DEF,
  parameter int MAX_WORDS = MAX_WORDS_DEF,
  parameter int WORD_LEN  = WORD_LEN_DEF,
  parameter int GA_W      = grid_aw(GRID_DIM),
  parameter int WA_W      = word_aw(MAX_WORDS, WORD_LEN)
) (
  input  logic              clk,
  input  logic              rst,
  gwm_in_if.sink            cmd,
  gwm_out_if.source         result,
  input  dims_t             dims,
  output logic              grid_we,
  output logic [GA_W-1:0]   grid_waddr,
  output logic              grid_re,
  output logic [GA_W-1:0]   grid_raddr,
  input  logic [CHAR_W-1:0] grid_rdata,
  output logic              word_we,
  output logic [WA_W-1:0]   word_waddr,
  output logic              word_re,
  output logic [WA_W-1:0]   word_raddr,
  input  logic [CHAR_W-1:0] word_rdata
);

  localparam int WordSlot = WORD_LEN + 1;
  localparam int IDX_W    = $clog2(WordSlot);
  localparam int SUM_W    = ((IDX_W > ROW_W) ? IDX_W : ROW_W) + 1;

  state_t            state;
  state_t            state_next;
  logic [ROW_W-1:0]  start_row;
  logic [COL_W-1:0]  start_col;
  logic [WA_W-1:0]   word_base;
  logic [IDX_W-1:0]  idx;
  logic              flag_h;
  logic              flag_v;
  logic              flag_d;
  logic              d_pend;
  logic              d_ok;
  logic              res_valid;
  logic              res_h;
  logic              res_v;
  logic              res_d;

  logic              acc;
  cmd_t              cmd_c;
  logic              start_ok;
  logic [SUM_W-1:0]  row_sum;
  logic [SUM_W-1:0]  col_sum;
  logic [SUM_W-1:0]  rd_row;
  logic [SUM_W-1:0]  rd_col;
  logic              h_ok;
  logic              v_ok;
  logic              eq;
  logic              is_end;
  logic              h_new;
  logic              last_pos;
  logic              res_free;

  // Handshake and decode of the incoming word.
  assign acc      = cmd.valid && cmd.ready;
  assign cmd_c    = cmd_t'(cmd.command);
  assign start_ok = (SUM_W'(cmd.cell_row) < SUM_W'(dims.num_rows)) &&
                    (SUM_W'(cmd.cell_col) < SUM_W'(dims.num_cols)) &&
                    (32'(cmd.word_index) < 32'(MAX_WORDS));
  assign res_free = !res_valid || result.ready;

  // Position of character idx along each direction, and its range checks.
  assign row_sum  = SUM_W'(start_row) + SUM_W'(idx);
  assign col_sum  = SUM_W'(start_col) + SUM_W'(idx);
  assign h_ok     = col_sum < SUM_W'(dims.num_cols);
  assign v_ok     = row_sum < SUM_W'(dims.num_rows);

  // Shared compare unit: grid byte against the current word character.
  assign eq       = grid_rdata == word_rdata;
  assign is_end   = word_rdata == END_MARK;
  assign h_new    = flag_h && h_ok && eq;
  assign last_pos = idx == IDX_W'(WORD_LEN);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (acc && cmd_c == CMD_SEARCH) begin
          state_next = start_ok ? S_H : S_DONE;
        end
      end
      S_H: state_next = S_V;
      S_V: begin
        priority if (is_end || last_pos) begin
          state_next = S_DONE;
        end else if (!(h_new || flag_v || flag_d)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_D;
        end
      end
      S_D: state_next = S_H;
      S_DONE: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs: handshake, memory writes, the word read and the grid read address per step.
  always_comb begin
    cmd.ready  = state == S_IDLE;
    grid_we    = acc && cmd_c == CMD_WRITE_CELL && (32'(cmd.cell_row) < 32'(GRID_DIM)) &&
                 (32'(cmd.cell_col) < 32'(GRID_DIM));
    grid_waddr = GA_W'(32'(cmd.cell_row) * 32'(GRID_DIM) + 32'(cmd.cell_col));
    word_we    = acc && cmd_c == CMD_WRITE_CHAR && (32'(cmd.word_index) < 32'(MAX_WORDS)) &&
                 (32'(cmd.char_pos) <= 32'(WORD_LEN));
    word_waddr = WA_W'(32'(cmd.word_index) * 32'(WordSlot) + 32'(cmd.char_pos));
    word_re    = state == S_H;
    word_raddr = word_base + WA_W'(idx);
    grid_re    = (state == S_H) || (state == S_V) || (state == S_D);
    rd_row     = SUM_W'(start_row);
    rd_col     = col_sum;
    unique case (state)
      S_V: begin
        rd_row = row_sum;
        rd_col = SUM_W'(start_col);
      end
      S_D: begin
        rd_row = row_sum;
        rd_col = col_sum;
      end
      default: ;
    endcase
    grid_raddr = GA_W'(32'(rd_row) * 32'(GRID_DIM) + 32'(rd_col));
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      d_pend    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && res_free) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      if (state == S_IDLE) begin
        d_pend <= 1'b0;
      end else if (state == S_D) begin
        d_pend <= 1'b1;
      end
    end
  end

  // Search datapath: start capture, per-direction flags, result register.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (acc && cmd_c == CMD_SEARCH) begin
          start_row <= cmd.cell_row;
          start_col <= cmd.cell_col;
          word_base <= WA_W'(32'(cmd.word_index) * 32'(WordSlot));
          idx       <= '0;
          flag_h    <= start_ok;
          flag_v    <= start_ok;
          flag_d    <= start_ok;
        end
      end
      S_H: begin
        // Diagonal cell of the previous character arrives now.
        if (d_pend) begin
          flag_d <= flag_d && d_ok && eq;
        end
      end
      S_V: begin
        if (!is_end) begin
          if (last_pos) begin
            // No newline in any slot: the word matches nowhere.
            flag_h <= 1'b0;
            flag_v <= 1'b0;
            flag_d <= 1'b0;
          end else begin
            flag_h <= h_new;
          end
        end
      end
      S_D: begin
        flag_v <= flag_v && v_ok && eq;
        d_ok   <= h_ok && v_ok;
        idx    <= idx + IDX_W'(1);
      end
      S_DONE: begin
        if (res_free) begin
          res_h <= flag_h;
          res_v <= flag_v;
          res_d <= flag_d;
        end
      end
      default: ;
    endcase
  end

  assign result.valid            = res_valid;
  assign result.match_horizontal = res_h;
  assign result.match_vertical   = res_v;
  assign result.match_diagonal   = res_d;

  // A diagonal compare is pending exactly when a character has gone by.
  a_d_pend: assert property (@(posedge clk) disable iff (rst)
    state == S_H |-> (d_pend == (idx != '0)))
    else $error("diagonal pending flag out of step with character index");

  // The character index never leaves the word slot.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    state == S_V |-> idx <= IDX_W'(WORD_LEN))
    else $error("character index beyond word slot");

  // A search from outside the grid or word range goes straight to done with all flags zero.
  a_bad_start: assert property (@(posedge clk) disable iff (rst)
    (acc && cmd_c == CMD_SEARCH && !start_ok) |=>
      (state == S_DONE && !flag_h && !flag_v && !flag_d))
    else $error("out-of-range search did not finish with zero flags");

  // A finished search loads the result register and frees the command side.
  a_done_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res_free) |=> (res_valid && state == S_IDLE))
    else $error("finished search did not load result");

endmodule

`default_nettype wire

// ===== hdl/grid_word_match.sv =====
// Grid word match: checks a stored word against a character grid from a start cell,
// going right, down and down-right. A write word is taken whenever the sequencer is idle;
// writes go back to back. A search checks the word character by character, up to its
// newline; a start out of range or a mismatch everywhere ends it early, and the next word
// is accepted once the result is loaded. Each character costs up to three grid reads.
// Reset clears the sequencer and sets columns and rows to min(GRID_DIM, 32); memories are not.
`default_nettype none

module grid_word_match import gwm_pkg::*; #(
  parameter int GRID_DIM  = GRID_DIM_DEF,
  parameter int MAX_WORDS = MAX_WORDS_DEF,
  parameter int WORD_LEN  = WORD_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  gwm_in_if.sink               cmd,
  gwm_out_if.source            result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  localparam int GA_W = grid_aw(GRID_DIM);
  localparam int WA_W = word_aw(MAX_WORDS, WORD_LEN);

  dims_t             dims;
  logic              grid_we;
  logic [GA_W-1:0]   grid_waddr;
  logic              grid_re;
  logic [GA_W-1:0]   grid_raddr;
  logic [CHAR_W-1:0] grid_rdata;
  logic              word_we;
  logic [WA_W-1:0]   word_waddr;
  logic              word_re;
  logic [WA_W-1:0]   word_raddr;
  logic [CHAR_W-1:0] word_rdata;

  // Grid size registers.
  gwm_cfg #(
    .GRID_DIM(GRID_DIM)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .dims     (dims)
  );

  // Grid store, one byte per cell, row-major.
  gwm_ram #(
    .DEPTH (GRID_DIM * GRID_DIM),
    .ADDR_W(GA_W),
    .DATA_W(CHAR_W)
  ) u_grid_ram (
    .clk  (clk),
    .we   (grid_we),
    .waddr(grid_waddr),
    .wdata(cmd.char_value),
    .re   (grid_re),
    .raddr(grid_raddr),
    .rdata(grid_rdata)
  );

  // Word store, WORD_LEN+1 byte slots per word.
  gwm_ram #(
    .DEPTH (MAX_WORDS * (WORD_LEN + 1)),
    .ADDR_W(WA_W),
    .DATA_W(CHAR_W)
  ) u_word_ram (
    .clk  (clk),
    .we   (word_we),
    .waddr(word_waddr),
    .wdata(cmd.char_value),
    .re   (word_re),
    .raddr(word_raddr),
    .rdata(word_rdata)
  );

  // Command decode and search sequencer.
  gwm_seq #(
    .GRID_DIM (GRID_DIM),
    .MAX_WORDS(MAX_WORDS),
    .WORD_LEN (WORD_LEN),
    .GA_W     (GA_W),
    .WA_W     (WA_W)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .result    (result),
    .dims      (dims),
    .grid_we   (grid_we),
    .grid_waddr(grid_waddr),
    .grid_re   (grid_re),
    .grid_raddr(grid_raddr),
    .grid_rdata(grid_rdata),
    .word_we   (word_we),
    .word_waddr(word_waddr),
    .word_re   (word_re),
    .word_raddr(word_raddr),
    .word_rdata(word_rdata)
  );

endmodule

`default_nettype wire
